@@ hw/rtl/shortest_longest_span_tracker_assert.svh @@
// Assertion macros for the span tracker; they use the clk and rst_n of the including module.
`ifndef SHORTEST_LONGEST_SPAN_TRACKER_ASSERT_SVH
`define SHORTEST_LONGEST_SPAN_TRACKER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SLST_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define SLST_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define SLST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/slst_pkg.sv @@
// Shared constants for the shortest and longest span tracker.
`timescale 1ns / 1ps

package slst_pkg;

  // Field widths.
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 11;
  localparam int COUNT_W = 11;

  // Default store depth and register reset value.
  localparam int MAX_ENTRIES_DEF = 1024;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // Reset value of the smallest gap.
  localparam logic [VAL_W-1:0] UINT_MAX_32 = 32'hFFFF_FFFF;

  // Status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

@@ hw/rtl/slst_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module slst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/shortest_longest_span_tracker.sv @@
// Top level of the shortest and longest span tracker.
//
//   Channel  | Signals                                   | Direction
//   ---------+-------------------------------------------+----------
//   in       | in_valid, in_ready, in_value              | input word
//   out      | out_valid, out_ready, out_status,         | result word
//            | out_count, out_spans_valid, out_shortest, |
//            | out_longest                               |
//   cfg      | cfg_we, cfg_wdata                         | capacity register
//
// An accepted word is scanned with one RAM read per stored value into the shared gap
// unit, then that unit drains, the word is committed and the result is output.
// The first word skips the scan and drain, and a rejected word goes straight to output.
// Reset is synchronous and active low; the RAM needs no clearing since only entries
// below the fill count are read. An untaken result holds the next word in its final
// state, with in_ready low, until the output register frees.
`timescale 1ns / 1ps

module shortest_longest_span_tracker
  import slst_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VAL_W-1:0]   in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_status,
  output logic [COUNT_W-1:0]        out_count,
  output logic                      out_spans_valid,
  output logic [VAL_W-1:0]          out_shortest,
  output logic [VAL_W-1:0]          out_longest,
  input  logic                      cfg_we,
  input  logic [CAP_W-1:0]          cfg_wdata
);

  `include "shortest_longest_span_tracker_assert.svh"

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_FIN
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CAP_W-1:0]          cap_r, cap_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [VAL_W-1:0]          least_r, least_nxt;
  logic signed [VAL_W-1:0]   low_r, low_nxt;
  logic signed [VAL_W-1:0]   high_r, high_nxt;
  logic signed [VAL_W-1:0]   val_r, val_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic                      rd_vld_r, rd_vld_nxt;
  logic                      gap_vld_r, gap_vld_nxt;
  logic [VAL_W-1:0]          gap_r, gap_nxt;
  logic                      status_r, status_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]        out_count_r, out_count_nxt;
  logic                      out_spans_r, out_spans_nxt;
  logic [VAL_W-1:0]          out_short_r, out_short_nxt;
  logic [VAL_W-1:0]          out_long_r, out_long_nxt;

  logic [LW-1:0]             cnt_ext;
  logic [LW-1:0]             cap_ext;
  logic [LW-1:0]             max_ext;
  logic [LW-1:0]             limit;
  logic                      full;
  logic [CW+COUNT_W-1:0]     cnt_wide;
  logic                      spans_ok;
  logic                      last_issue;

  logic                      ram_rd_en;
  logic                      ram_wr_en;
  logic [VAL_W-1:0]          ram_rd_data;
  logic signed [VAL_W-1:0]   rd_signed;

  // Value store.
  slst_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(count_r[AW-1:0]),
    .wr_data(val_r),
    .rd_en  (ram_rd_en),
    .rd_addr(idx_r),
    .rd_data(ram_rd_data)
  );

  // Fill limit is the smaller of the capacity register and the store depth.
  assign cnt_ext  = LW'(count_r);
  assign cap_ext  = LW'(cap_r);
  assign max_ext  = LW'(MAX_ENTRIES);
  assign limit    = (cap_ext < max_ext) ? cap_ext : max_ext;
  assign full     = (cnt_ext >= limit);
  assign cnt_wide = {{COUNT_W{1'b0}}, count_r};
  assign spans_ok = (cnt_ext >= LW'(2));
  assign last_issue = ((CW'(idx_r) + CW'(1)) == count_r);
  assign rd_signed  = $signed(ram_rd_data);

  assign ram_rd_en = (state_r == ST_SCAN);
  assign ram_wr_en = (state_r == ST_COMMIT);

  // Sequencer, shared gap unit and output register.
  always_comb begin
    state_nxt      = state_r;
    cap_nxt        = cap_r;
    count_nxt      = count_r;
    least_nxt      = least_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    rd_vld_nxt     = 1'b0;
    gap_vld_nxt    = rd_vld_r;
    gap_nxt        = gap_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_spans_nxt  = out_spans_r;
    out_short_nxt  = out_short_r;
    out_long_nxt   = out_long_r;

    // Configuration write.
    if (cfg_we) begin
      cap_nxt = cfg_wdata;
    end

    // Gap stage: absolute difference of a stored value and the new word.
    if (rd_vld_r) begin
      if (rd_signed >= val_r) begin
        gap_nxt = ram_rd_data - val_r;
      end else begin
        gap_nxt = val_r - ram_rd_data;
      end
    end

    // Compare stage: keep the smallest gap seen.
    if (gap_vld_r && (gap_r < least_r)) begin
      least_nxt = gap_r;
    end

    // A taken result frees the output register.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          val_nxt = in_value;
          idx_nxt = '0;
          if (full) begin
            status_nxt = STATUS_FULL;
            state_nxt  = ST_FIN;
          end else if (count_r == '0) begin
            status_nxt = STATUS_OK;
            state_nxt  = ST_COMMIT;
          end else begin
            status_nxt = STATUS_OK;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_vld_nxt = 1'b1;
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !gap_vld_r) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (count_r == '0) begin
          low_nxt  = val_r;
          high_nxt = val_r;
        end else begin
          if (val_r < low_r) begin
            low_nxt = val_r;
          end
          if (val_r >= high_r) begin
            high_nxt = val_r;
          end
        end
        count_nxt = count_r + CW'(1);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = cnt_wide[COUNT_W-1:0];
          out_spans_nxt  = spans_ok;
          out_short_nxt  = spans_ok ? least_r : '0;
          out_long_nxt   = spans_ok ? VAL_W'(high_r - low_r) : '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      least_r     <= UINT_MAX_32;
      rd_vld_r    <= 1'b0;
      gap_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cap_r        <= cap_nxt;
      count_r      <= count_nxt;
      least_r      <= least_nxt;
      low_r        <= low_nxt;
      high_r       <= high_nxt;
      val_r        <= val_nxt;
      idx_r        <= idx_nxt;
      rd_vld_r     <= rd_vld_nxt;
      gap_vld_r    <= gap_vld_nxt;
      gap_r        <= gap_nxt;
      status_r     <= status_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= out_count_nxt;
      out_spans_r  <= out_spans_nxt;
      out_short_r  <= out_short_nxt;
      out_long_r   <= out_long_nxt;
    end
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_count       = out_count_r;
  assign out_spans_valid = out_spans_r;
  assign out_shortest    = out_short_r;
  assign out_longest     = out_long_r;

  // The fill count never passes the store depth.
  `SLST_ASSERT_ALWAYS(a_count_in_range, cnt_ext <= max_ext, "fill count above store depth")
  // A rejected word never reaches the store.
  `SLST_ASSERT_IMPLIES(a_reject_no_commit, state_r == ST_COMMIT, status_r == STATUS_OK,
    "rejected word reached commit")
  // The scan only reads entries that were written.
  `SLST_ASSERT_IMPLIES(a_scan_in_fill, state_r == ST_SCAN, CW'(idx_r) < count_r,
    "scan address beyond fill count")
  // The smallest gap never grows.
  `SLST_ASSERT_NEXT(a_gap_monotonic, 1'b1, least_r <= $past(least_r), "smallest gap grew")

endmodule
